FILE: rtl/core/sepho_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepho_pkg
// Shared types and codes for the stepper position and homing controller.
// ----------------------------------------------------------------------------
package sepho_pkg;

    localparam int POS_W = 32;

    typedef enum logic [2:0] {
        PH_TRACK   = 3'd0,
        PH_TO_ZERO = 3'd1,
        PH_SEARCH1 = 3'd2,
        PH_REVERSE = 3'd3,
        PH_RETURN  = 3'd4,
        PH_SEARCH2 = 3'd5
    } phase_t;

    localparam logic [1:0] HS_IDLE  = 2'd0;
    localparam logic [1:0] HS_BUSY  = 2'd1;
    localparam logic [1:0] HS_FOUND = 2'd2;
    localparam logic [1:0] HS_FAIL  = 2'd3;

    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // Controller state other than the search step count
    typedef struct packed {
        logic signed [POS_W-1:0] position_count;
        logic                    direction_bit;
        logic                    last_a;
        logic                    last_b;
        phase_t                  homing_phase;
        logic [1:0]              homing_result;
    } state_t;

    // One tick's input
    typedef struct packed {
        logic signed [POS_W-1:0] target_count;
        logic                    enc_a;
        logic                    enc_b;
        logic                    enc_index;
        logic                    zero_request;
        logic                    home_request;
    } tick_t;

    // One tick's result
    typedef struct packed {
        logic                    step_pulse;
        logic                    drive_direction;
        logic                    direction_flipped;
        logic signed [POS_W-1:0] position;
        logic                    at_target;
        logic [1:0]              home_status;
    } result_t;

endpackage

FILE: rtl/core/stepper_encoder_position_homing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_encoder_position_homing
// Closed-loop stepper position controller with encoder feedback and homing.
// ----------------------------------------------------------------------------
// Each input transaction is one step-period tick and yields exactly one
// output transaction. A tick is taken in every cycle whenever the output
// register is empty or is being emptied in the same cycle, so the block
// sustains one tick per clock; its result appears in the cycle after it
// is taken. The whole tick (compare against target, saturating count
// update, homing sequencer) is one pass of logic from the state registers
// and the incoming transaction into the state and output registers. While
// tracking, a drive direction that points away from the target is reversed
// on a tick with no pulse; otherwise, off target, a pulse is issued and any
// A/B change since the last stepped tick moves the count by one. Homing
// drives to zero, then, if the index is low, searches half a revolution,
// reverses, returns and searches again, ending as found or failed.
// ----------------------------------------------------------------------------
module stepper_encoder_position_homing #(
    parameter int STEPS_PER_REV = 200
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: target_count[31:0], enc_a, enc_b, enc_index,
    // zero_request, home_request, zero fill to 40 bits
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: step_pulse, drive_direction, direction_flipped,
    // position[31:0], at_target, home_status[1:0], zero fill to 40 bits
    output logic [39:0] m_axis_tdata
);
    import sepho_pkg::*;

    // Half a revolution of search pulses; the counter just holds that value
    localparam int HALF_REV = STEPS_PER_REV / 2;
    localparam int CNT_W    = $clog2(HALF_REV + 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] search_cnt_reg;
    logic [CNT_W-1:0] search_cnt_next;
    tick_t            tick;
    result_t          result_next;
    result_t          result_reg;
    logic             out_valid_reg;
    logic             take;

    // Unpack the incoming transaction
    assign tick.target_count = s_axis_tdata[31:0];
    assign tick.enc_a        = s_axis_tdata[32];
    assign tick.enc_b        = s_axis_tdata[33];
    assign tick.enc_index    = s_axis_tdata[34];
    assign tick.zero_request = s_axis_tdata[35];
    assign tick.home_request = s_axis_tdata[36];

    // Accept while the output register is free or draining this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    sepho_step #(
        .HALF_REV (HALF_REV),
        .CNT_W    (CNT_W)
    ) u_step (
        .state           (state_reg),
        .search_cnt      (search_cnt_reg),
        .tick            (tick),
        .state_next      (state_next),
        .search_cnt_next (search_cnt_next),
        .result          (result_next)
    );

    // Advance controller state only on an accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.position_count <= '0;
            state_reg.direction_bit  <= DIR_CW;
            state_reg.last_a         <= 1'b0;
            state_reg.last_b         <= 1'b0;
            state_reg.homing_phase   <= PH_TRACK;
            state_reg.homing_result  <= HS_IDLE;
            search_cnt_reg           <= '0;
            out_valid_reg            <= 1'b0;
        end
        else begin
            if (take) begin
                state_reg      <= state_next;
                search_cnt_reg <= search_cnt_next;
            end
            // Hold the result until the downstream side takes it
            if (take)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            result_reg.home_status,
                            result_reg.at_target,
                            result_reg.position,
                            result_reg.direction_flipped,
                            result_reg.drive_direction,
                            result_reg.step_pulse};

endmodule

FILE: rtl/core/sepho_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepho_step
// Next-state and result logic for one step-period tick.
// ----------------------------------------------------------------------------
module sepho_step #(
    parameter int HALF_REV = 100,
    parameter int CNT_W    = 7
) (
    input  sepho_pkg::state_t  state,
    input  logic [CNT_W-1:0]   search_cnt,
    input  sepho_pkg::tick_t   tick,
    output sepho_pkg::state_t  state_next,
    output logic [CNT_W-1:0]   search_cnt_next,
    output sepho_pkg::result_t result
);
    import sepho_pkg::*;

    localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(HALF_REV);

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic                    dir;
        logic                    la;
        logic                    lb;
        logic                    pulse;
        logic                    flip;
    } drive_t;

    // One closed-loop move toward a target
    function automatic drive_t drive_toward(input state_t s,
                                            input logic signed [POS_W-1:0] tgt,
                                            input logic a,
                                            input logic b);
        drive_t d;
        logic   want;
        d.pos   = s.position_count;
        d.dir   = s.direction_bit;
        d.la    = s.last_a;
        d.lb    = s.last_b;
        d.pulse = 1'b0;
        d.flip  = 1'b0;
        want    = (s.position_count < tgt) ? DIR_CW : DIR_CCW;
        if (s.position_count != tgt) begin
            if (want != s.direction_bit) begin
                d.dir  = want;
                d.flip = 1'b1;
            end
            else begin
                d.pulse = 1'b1;
                if (a != s.last_a || b != s.last_b) begin
                    if (s.direction_bit == DIR_CW) begin
                        if (s.position_count != POS_MAX)
                            d.pos = s.position_count + 1;
                    end
                    else begin
                        if (s.position_count != POS_MIN)
                            d.pos = s.position_count - 1;
                    end
                end
                d.la = a;
                d.lb = b;
            end
        end
        return d;
    endfunction

    state_t           s0;
    logic [CNT_W-1:0] cnt0;
    logic [CNT_W-1:0] cnt_inc;
    drive_t           drv;

    always_comb
    begin
        // Apply calibrate, then a homing start while tracking
        s0   = state;
        cnt0 = search_cnt;
        if (tick.zero_request)
            s0.position_count = '0;
        if (tick.home_request && state.homing_phase == PH_TRACK) begin
            s0.homing_phase  = PH_TO_ZERO;
            s0.homing_result = HS_BUSY;
            cnt0             = '0;
        end
    end

    assign cnt_inc = cnt0 + 1'b1;

    always_comb
    begin
        state_next      = s0;
        search_cnt_next = cnt0;
        result          = '0;
        drv             = drive_toward(s0, (s0.homing_phase == PH_TRACK) ?
                                       tick.target_count : '0, tick.enc_a, tick.enc_b);
        case (s0.homing_phase)
            PH_TRACK:
            begin
                state_next.position_count = drv.pos;
                state_next.direction_bit  = drv.dir;
                state_next.last_a         = drv.la;
                state_next.last_b         = drv.lb;
                result.step_pulse         = drv.pulse;
                result.direction_flipped  = drv.flip;
                result.at_target          = (drv.pos == tick.target_count);
            end
            PH_TO_ZERO:
            begin
                if (s0.position_count == '0) begin
                    if (tick.enc_index) begin
                        state_next.homing_phase  = PH_TRACK;
                        state_next.homing_result = HS_FOUND;
                    end
                    else begin
                        state_next.homing_phase = PH_SEARCH1;
                        search_cnt_next         = '0;
                    end
                end
                else begin
                    state_next.position_count = drv.pos;
                    state_next.direction_bit  = drv.dir;
                    state_next.last_a         = drv.la;
                    state_next.last_b         = drv.lb;
                    result.step_pulse         = drv.pulse;
                    result.direction_flipped  = drv.flip;
                end
            end
            PH_SEARCH1, PH_SEARCH2:
            begin
                result.step_pulse = 1'b1;
                search_cnt_next   = cnt_inc;
                if (tick.enc_index) begin
                    state_next.homing_phase  = PH_TRACK;
                    state_next.homing_result = HS_FOUND;
                    search_cnt_next          = '0;
                end
                else if (cnt_inc >= HALF_CNT) begin
                    search_cnt_next = '0;
                    if (s0.homing_phase == PH_SEARCH1)
                        state_next.homing_phase = PH_REVERSE;
                    else begin
                        state_next.homing_phase  = PH_TRACK;
                        state_next.homing_result = HS_FAIL;
                    end
                end
            end
            PH_REVERSE:
            begin
                state_next.direction_bit = ~s0.direction_bit;
                result.direction_flipped = 1'b1;
                state_next.homing_phase  = PH_RETURN;
                search_cnt_next          = '0;
            end
            PH_RETURN:
            begin
                result.step_pulse = 1'b1;
                search_cnt_next   = cnt_inc;
                if (cnt_inc >= HALF_CNT) begin
                    search_cnt_next         = '0;
                    state_next.homing_phase = PH_SEARCH2;
                end
            end
            default:
            begin
                state_next.homing_phase = PH_TRACK;
            end
        endcase
        result.drive_direction = state_next.direction_bit;
        result.position        = state_next.position_count;
        result.home_status     = state_next.homing_result;
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stepper position and homing controller.
// ----------------------------------------------------------------------------
// Ticks are driven as input transactions. A directed table goes first. It
// covers reset, the target extremes, flips, zeroing and a homing run that
// finds the index at once. Random ticks follow. They are mostly tracking
// ticks with targets close to the count, with homing runs in between that
// end as found or failed. A behavioural copy of the controller works out
// each result when the tick is taken. Each output transaction is checked
// field by field against the oldest result still waiting.
// ----------------------------------------------------------------------------
module tb;

    import sepho_pkg::*;

    localparam int HALF_REV     = 200 / 2;
    localparam int RANDOM_TICKS = 1900;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_axis_tready;
    // tdata from bit 0: target_count[31:0], enc_a, enc_b, enc_index,
    // zero_request, home_request, zero fill to 40 bits
    logic [39:0] s_tdata;
    logic        m_axis_tvalid;
    logic        m_tready;
    // tdata from bit 0: step_pulse, drive_direction, direction_flipped,
    // position[31:0], at_target, home_status[1:0], zero fill to 40 bits
    logic [39:0] m_axis_tdata;

    // One row of the directed table; want holds a typed-in result if typed
    typedef struct {
        tick_t   tick;
        bit      typed;
        result_t want;
    } stim_row_t;

    // Controller copy: state after every tick taken so far
    logic signed [31:0] ctl_pos;
    logic               ctl_dir;
    logic               ctl_last_a;
    logic               ctl_last_b;
    phase_t             ctl_phase;
    int                 ctl_steps;
    logic [1:0]         ctl_home;

    result_t   pending_results[$];
    stim_row_t directed_rows[$];

    int  fault_count  = 0;
    int  report_count = 0;
    bit  hold_off_req = 1'b0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;

    // Homing run plan for the random part: tick on which the index shows
    int  home_ticks   = 0;
    int  index_at     = -1;

    stepper_encoder_position_homing i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hold reset from the start, release on a rising edge, never again
    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Controller copy
    // ------------------------------------------------------------------------

    // One closed-loop tick toward tgt: flip first if pointing away, else step
    function automatic void steer_toward(input logic signed [31:0] tgt,
                                         input logic a, input logic b,
                                         inout logic pulse, inout logic flip);
        logic wanted_dir;
        if (ctl_pos == tgt)
            return;
        wanted_dir = (ctl_pos < tgt) ? DIR_CW : DIR_CCW;
        if (wanted_dir != ctl_dir)
        begin
            ctl_dir = wanted_dir;
            flip    = 1'b1;
            return;
        end
        pulse = 1'b1;
        if (a != ctl_last_a || b != ctl_last_b)
        begin
            // Saturate at the count limits
            if (ctl_dir == DIR_CW)
            begin
                if (ctl_pos != POS_MAX)
                    ctl_pos = ctl_pos + 1;
            end
            else
            begin
                if (ctl_pos != POS_MIN)
                    ctl_pos = ctl_pos - 1;
            end
        end
        ctl_last_a = a;
        ctl_last_b = b;
    endfunction

    function automatic void reset_controller();
        ctl_pos    = '0;
        ctl_dir    = DIR_CW;
        ctl_last_a = 1'b0;
        ctl_last_b = 1'b0;
        ctl_phase  = PH_TRACK;
        ctl_steps  = 0;
        ctl_home   = HS_IDLE;
    endfunction

    // Advance the copy by one tick and return the result it gives
    function automatic result_t advance_controller(input tick_t t);
        result_t            r;
        logic signed [31:0] tgt;
        logic               pulse;
        logic               flip;
        logic               at;
        tgt   = t.target_count;
        pulse = 1'b0;
        flip  = 1'b0;
        at    = 1'b0;

        // Zero first, then a home request while tracking, then the action
        if (t.zero_request)
            ctl_pos = '0;
        if (t.home_request && ctl_phase == PH_TRACK)
        begin
            ctl_phase = PH_TO_ZERO;
            ctl_home  = HS_BUSY;
            ctl_steps = 0;
        end

        case (ctl_phase)
            PH_TRACK:
            begin
                steer_toward(tgt, t.enc_a, t.enc_b, pulse, flip);
                at = (ctl_pos == tgt);
            end
            PH_TO_ZERO:
            begin
                if (ctl_pos == 0)
                begin
                    if (t.enc_index)
                    begin
                        ctl_phase = PH_TRACK;
                        ctl_home  = HS_FOUND;
                    end
                    else
                    begin
                        ctl_phase = PH_SEARCH1;
                        ctl_steps = 0;
                    end
                end
                else
                    steer_toward('0, t.enc_a, t.enc_b, pulse, flip);
            end
            PH_SEARCH1, PH_SEARCH2:
            begin
                pulse     = 1'b1;
                ctl_steps = ctl_steps + 1;
                if (t.enc_index)
                begin
                    ctl_phase = PH_TRACK;
                    ctl_home  = HS_FOUND;
                    ctl_steps = 0;
                end
                else if (ctl_steps >= HALF_REV)
                begin
                    ctl_steps = 0;
                    if (ctl_phase == PH_SEARCH1)
                        ctl_phase = PH_REVERSE;
                    else
                    begin
                        ctl_phase = PH_TRACK;
                        ctl_home  = HS_FAIL;
                    end
                end
            end
            PH_REVERSE:
            begin
                ctl_dir   = ~ctl_dir;
                flip      = 1'b1;
                ctl_phase = PH_RETURN;
                ctl_steps = 0;
            end
            PH_RETURN:
            begin
                pulse     = 1'b1;
                ctl_steps = ctl_steps + 1;
                if (ctl_steps >= HALF_REV)
                begin
                    ctl_steps = 0;
                    ctl_phase = PH_SEARCH2;
                end
            end
            default:
                ctl_phase = PH_TRACK;
        endcase

        r.step_pulse        = pulse;
        r.drive_direction   = ctl_dir;
        r.direction_flipped = flip;
        r.position          = ctl_pos;
        r.at_target         = at;
        r.home_status       = ctl_home;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly back to back, sometimes a short gap, now and then a long gap
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic stim_row_t row(input logic signed [31:0] tgt,
                                      input bit a, input bit b, input bit idx,
                                      input bit z, input bit h, input bit typed,
                                      input bit p, input bit d, input bit f,
                                      input logic signed [31:0] pos,
                                      input bit at, input logic [1:0] hs);
        stim_row_t s;
        s.tick.target_count       = tgt;
        s.tick.enc_a              = a;
        s.tick.enc_b              = b;
        s.tick.enc_index          = idx;
        s.tick.zero_request       = z;
        s.tick.home_request       = h;
        s.typed                   = typed;
        s.want.step_pulse         = p;
        s.want.drive_direction    = d;
        s.want.direction_flipped  = f;
        s.want.position           = pos;
        s.want.at_target          = at;
        s.want.home_status        = hs;
        return s;
    endfunction

    // Build a random tick from the copy's current phase
    function automatic tick_t make_tick();
        tick_t t;
        int    r;
        t.target_count = $urandom;
        t.enc_a        = $urandom_range(0, 1);
        t.enc_b        = $urandom_range(0, 1);
        t.enc_index    = $urandom_range(0, 1);
        t.zero_request = ($urandom_range(0, 99) < 2);
        t.home_request = 1'b0;

        if (ctl_phase == PH_TRACK)
        begin
            // Keep most targets within a few counts so that steps land
            r = $urandom_range(0, 99);
            if (r < 80)
                t.target_count = ctl_pos + ($signed($urandom_range(0, 16)) - 8);
            else if (r < 88)
                t.target_count = ctl_pos;
            else if (r < 90)
                t.target_count = ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN;
            if ($urandom_range(0, 99) < 2)
            begin
                // Start a homing run; in near half the index is never raised
                t.home_request = 1'b1;
                home_ticks     = 0;
                if ($urandom_range(0, 99) < 45)
                    index_at = -1;
                else
                    index_at = $urandom_range(0, 420);
                t.enc_index = (index_at == 0);
            end
        end
        else
        begin
            // Homing: index only on the planned tick, stray home requests
            home_ticks   = home_ticks + 1;
            t.enc_index  = (home_ticks == index_at);
            t.home_request = ($urandom_range(0, 99) < 10);
        end
        return t;
    endfunction

    // Offer one tick and hold it until the transaction completes; valid is
    // left high so a back-to-back tick follows without a dip
    task automatic send_tick(input tick_t t, input bit typed,
                             input result_t want);
        int      gap;
        result_t got;
        gap = tx_calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, t.home_request, t.zero_request, t.enc_index,
                     t.enc_b, t.enc_a, t.target_count};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        got = advance_controller(t);
        pending_results.push_back(typed ? want : got);
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic check_result(input logic [39:0] d);
        result_t w;
        bit      bad;
        if (pending_results.size() == 0)
        begin
            fault_count = fault_count + 1;
            if (report_count < 10)
                $display("%0t: result with nothing waiting: %h", $realtime, d);
            report_count = report_count + 1;
            return;
        end
        w   = pending_results.pop_front();
        bad = (d[0] !== w.step_pulse) || (d[1] !== w.drive_direction)
            || (d[2] !== w.direction_flipped) || (d[34:3] !== w.position)
            || (d[35] !== w.at_target) || (d[37:36] !== w.home_status);
        if (bad)
        begin
            fault_count = fault_count + 1;
            if (report_count < 10)
            begin
                $display("%0t: expected pulse %b dir %b flip %b pos %0d at %b home %0d",
                         $realtime, w.step_pulse, w.drive_direction,
                         w.direction_flipped, w.position, w.at_target,
                         w.home_status);
                $display("%0t: got      pulse %b dir %b flip %b pos %0d at %b home %0d",
                         $realtime, d[0], d[1], d[2], $signed(d[34:3]),
                         d[35], d[37:36]);
            end
            report_count = report_count + 1;
        end
    endtask

    // Receiver: take output transactions, stall at random, and hold off
    // for a long stretch when asked so the block fills and stalls its input
    initial
    begin
        int stall_left;
        int cyc;
        stall_left = 0;
        cyc        = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_tready)
                check_result(m_axis_tdata);
            cyc = cyc + 1;
            if (cyc % 300 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = 400;
            end
            if (stall_left > 0)
            begin
                m_tready   <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        tick_t   t;
        result_t none;
        none = '0;
        reset_controller();

        // After reset: on target at zero, then full-scale targets both ways
        directed_rows.push_back(row(0, 0, 0, 0, 0, 0, 1,
                                    0, DIR_CW, 0, 0, 1, HS_IDLE));
        // Pulse without A/B change leaves the count alone
        directed_rows.push_back(row(POS_MAX, 0, 0, 0, 0, 0, 1,
                                    1, DIR_CW, 0, 0, 0, HS_IDLE));
        directed_rows.push_back(row(POS_MAX, 1, 0, 0, 0, 0, 1,
                                    1, DIR_CW, 0, 1, 0, HS_IDLE));
        // Target behind: flip only, no pulse
        directed_rows.push_back(row(POS_MIN, 1, 0, 0, 0, 0, 1,
                                    0, DIR_CCW, 1, 1, 0, HS_IDLE));
        directed_rows.push_back(row(POS_MIN, 1, 1, 0, 0, 0, 1,
                                    1, DIR_CCW, 0, 0, 0, HS_IDLE));
        directed_rows.push_back(row(POS_MIN, 0, 1, 0, 0, 0, 1,
                                    1, DIR_CCW, 0, -1, 0, HS_IDLE));
        // Zero applied before the compare, so the direction flips
        directed_rows.push_back(row(5, 0, 1, 0, 1, 0, 1,
                                    0, DIR_CW, 1, 0, 0, HS_IDLE));
        // Homing at zero with the index high finds it at once
        directed_rows.push_back(row(0, 0, 1, 1, 0, 1, 1,
                                    0, DIR_CW, 0, 0, 0, HS_FOUND));
        // Move off zero, then home: drive back, ignore a second request
        directed_rows.push_back(row(3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(3, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(3, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(3, 1, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(3, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // At zero with the index low: first search, then index mid-search
        directed_rows.push_back(row(3, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(3, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(3, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Zero and home on the same tick; the run is left to fail below
        directed_rows.push_back(row(7, 1, 1, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0));

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (directed_rows[i])
            send_tick(directed_rows[i].tick, directed_rows[i].typed,
                      directed_rows[i].want);

        for (int n = 0; n < RANDOM_TICKS; n++)
        begin
            if (n % 150 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            if (n == 600)
                hold_off_req = 1'b1;
            if (n == 1200)
            begin
                // Drop valid and drain every outstanding result
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            t = make_tick();
            send_tick(t, 1'b0, none);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
